[rtl/core/cdlos_pkg.sv]
// Shared types and constants for the crack disk line-of-sight block.
// Used by the neighbor memory, the shared multiplier and the top-level sequencer.
// No dependencies.
package cdlos_pkg;

    // Operation codes of an input transaction
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_SET_A  = 3'd2;
    localparam logic [2:0] OP_QPOINT = 3'd3;
    localparam logic [2:0] OP_QPAIR  = 3'd4;

    // Operand pairs of the three-term dot product
    localparam logic [2:0] DS_DA = 3'd0;  // (B-A) . normal of A
    localparam logic [2:0] DS_MM = 3'd1;  // m . m, normalized magnitudes
    localparam logic [2:0] DS_VA = 3'd2;  // v . normal of A
    localparam logic [2:0] DS_VB = 3'd3;  // v . normal of B
    localparam logic [2:0] DS_UN = 3'd4;  // (A-O) . neighbor normal
    localparam logic [2:0] DS_DN = 3'd5;  // (B-A) . neighbor normal

    // 0.75/pi in Q0.32
    localparam logic [29:0] VOL_K     = 30'd1025347913;
    localparam int          CUBE_MSB  = 21;
    localparam int          DIV_STEPS = 30;
    localparam int          COS_SHIFT = 26;
    localparam int          NORM_BITS = 14;

    typedef logic signed [33:0] t_mop;
    typedef logic signed [67:0] t_prod;

    typedef struct packed {
        logic [23:0]        id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic               broken;
        logic [31:0]        rsq;
    } t_nb_entry;

endpackage

[rtl/core/crack_disk_line_of_sight.sv]
// Crack disk line-of-sight test: neighbor list, particle A and the query sequencer.
// Depends on cdlos_pkg, cdlos_nb_mem and cdlos_mul.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries one transaction
// per operation: clear list, append neighbor, set particle A, point query or
// pair query. Only the two queries produce a transaction on the output
// channel (o_out_valid / i_out_ready) with the visible bit and the sticky
// overflow flag. o_in_ready is high only while the sequencer is idle.
// Work per transaction, all of it going through one shared multiplier:
//   clear, set A, dropped append: done in the idle state on acceptance.
//   append: a bit-serial cube root of 22 steps, then the square of the root.
//   point query: axis differences, a dot product when A is broken, then the walk.
//   pair query: differences, normalize shifts, a magnitude dot product, up to
//   two cosine tests, then the walk. Neighbor walk: a check per skipped
//   neighbor; per broken neighbor two dot products, a shift-subtract divide
//   and three axis steps; it stops at the first hit.
// A finished result sits in the output register while the next transaction
// is accepted; if the receiver stalls with a result still pending, the next
// query waits in its final state. Reset empties the list, clears the
// overflow flag and particle A, and drops any pending result.
module crack_disk_line_of_sight #(
    parameter int LIST_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [23:0]        i_particle_id,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_norm_x,
    input  logic signed [15:0] i_norm_y,
    input  logic signed [15:0] i_norm_z,
    input  logic               i_broken,
    input  logic [31:0]        i_volume,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_visible,
    output logic               o_list_overflowed
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int NB = cdlos_pkg::NORM_BITS;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_AP_MUL = 5'd1;
    localparam logic [4:0] ST_AP_T   = 5'd2;
    localparam logic [4:0] ST_CB_SQ  = 5'd3;
    localparam logic [4:0] ST_CB_LO  = 5'd4;
    localparam logic [4:0] ST_CB_HI  = 5'd5;
    localparam logic [4:0] ST_CB_CMP = 5'd6;
    localparam logic [4:0] ST_RS_MUL = 5'd7;
    localparam logic [4:0] ST_RS_WR  = 5'd8;
    localparam logic [4:0] ST_Q_DIFF = 5'd9;
    localparam logic [4:0] ST_PT_CHK = 5'd10;
    localparam logic [4:0] ST_NORM   = 5'd11;
    localparam logic [4:0] ST_CS_DD  = 5'd12;
    localparam logic [4:0] ST_CS_S   = 5'd13;
    localparam logic [4:0] ST_CS_SQ  = 5'd14;
    localparam logic [4:0] ST_CS_EV  = 5'd15;
    localparam logic [4:0] ST_WALK   = 5'd16;
    localparam logic [4:0] ST_WK_CHK = 5'd17;
    localparam logic [4:0] ST_WK_AN  = 5'd18;
    localparam logic [4:0] ST_WK_BN  = 5'd19;
    localparam logic [4:0] ST_DIV    = 5'd20;
    localparam logic [4:0] ST_AX_MUL = 5'd21;
    localparam logic [4:0] ST_AX_E   = 5'd22;
    localparam logic [4:0] ST_AX_SQ  = 5'd23;
    localparam logic [4:0] ST_AX_ACC = 5'd24;
    localparam logic [4:0] ST_DOT    = 5'd25;
    localparam logic [4:0] ST_RESULT = 5'd26;

    // Control state
    logic [4:0]         r_state;
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic [23:0]        r_a_id;
    logic signed [31:0] r_a_pos [3];
    logic signed [15:0] r_a_nrm [3];
    logic               r_a_brk;
    logic               r_o_valid;
    logic               r_o_vis;
    logic               r_o_ovf;

    // Latched transaction
    logic [2:0]         r_op;
    logic [23:0]        r_id;
    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_nrm [3];
    logic               r_brk;
    logic [31:0]        r_vol;

    // Query datapath
    logic signed [32:0] r_d [3];
    logic [31:0]        r_m [3];
    logic               r_dneg [3];
    logic signed [32:0] r_u [3];
    logic signed [51:0] r_acc;
    logic [1:0]         r_j;
    logic [2:0]         r_dsel;
    logic [4:0]         r_ret;
    logic [29:0]        r_dd;
    logic signed [31:0] r_s;
    logic               r_cos_neg;
    logic               r_hide;
    logic               r_vis;
    logic [CW-1:0]      r_k;
    cdlos_pkg::t_nb_entry r_nb;
    logic signed [51:0] r_an;
    logic [50:0]        r_bm;
    logic [50:0]        r_rem;
    logic [30:0]        r_lam;
    logic [4:0]         r_cnt;
    logic [29:0]        r_em;
    logic [61:0]        r_sum;

    // Append datapath
    logic [29:0]        r_t;
    logic [21:0]        r_c;
    logic [4:0]         r_bit;
    logic [11:0]        r_sq_hi;
    logic [53:0]        r_lo;

    // Shared unit and memory connections
    cdlos_pkg::t_mop    w_mul_a;
    cdlos_pkg::t_mop    w_mul_b;
    cdlos_pkg::t_prod   w_prod;
    cdlos_pkg::t_nb_entry w_rdata;
    cdlos_pkg::t_nb_entry w_wdata;
    logic               w_mem_we;

    // Combinational helpers
    logic               w_in_acc;
    logic [1:0]         w_jj;
    logic signed [15:0] w_nbn [3];
    logic signed [14:0] w_v [3];
    logic signed [32:0] w_diff [3];
    logic signed [51:0] w_p52;
    logic signed [51:0] w_acc_n;
    logic [21:0]        w_tr;
    logic [66:0]        w_cube;
    logic               w_norm_big;
    logic               w_pass;
    logic               w_hide_n;
    logic signed [51:0] w_bn;
    logic [50:0]        w_am;
    logic [50:0]        w_bm;
    logic               w_miss_rng;
    logic [51:0]        w_rem2;
    logic [31:0]        w_absd;
    logic [63:0]        w_rnd;
    logic signed [34:0] w_tm;
    logic signed [34:0] w_e;
    logic [34:0]        w_em;
    logic [61:0]        w_sum_n;
    logic               w_skip;
    cdlos_pkg::t_mop    w_dot_a;
    cdlos_pkg::t_mop    w_dot_b;

    assign o_in_ready        = (r_state == ST_IDLE);
    assign w_in_acc          = i_in_valid && o_in_ready;
    assign o_out_valid       = r_o_valid;
    assign o_visible         = r_o_vis;
    assign o_list_overflowed = r_o_ovf;

    assign w_nbn[0] = r_nb.nrm_x;
    assign w_nbn[1] = r_nb.nrm_y;
    assign w_nbn[2] = r_nb.nrm_z;

    // Per-axis terms: differences, normalized signed magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = 33'(r_pos[i]) - 33'(r_a_pos[i]);
            w_v[i]    = r_dneg[i] ? -$signed({1'b0, r_m[i][NB-1:0]})
                                  :  $signed({1'b0, r_m[i][NB-1:0]});
        end
    end

    assign w_jj       = (r_j == 2'd3) ? 2'd0 : r_j;
    assign w_p52      = $signed(w_prod[51:0]);
    assign w_acc_n    = (r_j == 2'd1) ? w_p52 : (r_acc + w_p52);
    assign w_norm_big = (|r_m[0][31:NB]) || (|r_m[1][31:NB]) || (|r_m[2][31:NB]);

    // Cube root trial and cube of the trial
    assign w_tr   = r_c | (22'd1 << r_bit);
    assign w_cube = 67'({w_prod[33:0], 32'd0}) + 67'(r_lo);

    // Cosine test against 0.5 by squaring
    assign w_pass   = (r_cos_neg ? (r_s < 32'sd0) : (r_s > 32'sd0)) &&
                      (w_prod[63:0] > 64'({r_dd, 26'd0}));
    assign w_hide_n = r_hide && w_pass;

    // Crossing range check a/b inside [0,1]
    assign w_bn       = -r_acc;
    assign w_am       = r_an[51] ? 51'(-r_an) : 51'(r_an);
    assign w_bm       = w_bn[51] ? 51'(-w_bn) : 51'(w_bn);
    assign w_miss_rng = (w_bn == 52'sd0) ||
                        ((w_bn > 52'sd0) && ((r_an < 52'sd0) || (r_an > w_bn))) ||
                        ((w_bn < 52'sd0) && ((r_an > 52'sd0) || (r_an < w_bn)));
    assign w_rem2     = {r_rem, 1'b0};

    // Point on the plane, one axis at a time
    assign w_absd  = r_d[w_jj][32] ? 32'(-r_d[w_jj]) : 32'(r_d[w_jj]);
    assign w_rnd   = w_prod[63:0] + 64'd536870912;
    assign w_tm    = $signed({2'b00, w_rnd[62:30]});
    assign w_e     = r_d[w_jj][32] ? (35'(r_u[w_jj]) - w_tm) : (35'(r_u[w_jj]) + w_tm);
    assign w_em    = w_e[34] ? 35'(-w_e) : 35'(w_e);
    assign w_sum_n = r_sum + 62'(w_prod[59:0]);

    assign w_skip = !w_rdata.broken || (w_rdata.id == r_a_id) ||
                    ((r_op == cdlos_pkg::OP_QPAIR) && (w_rdata.id == r_id));

    // Dot product operand pairs
    always_comb begin
        w_dot_a = '0;
        w_dot_b = '0;
        case (r_dsel)
            cdlos_pkg::DS_DA: begin
                w_dot_a = cdlos_pkg::t_mop'(r_d[w_jj]);
                w_dot_b = cdlos_pkg::t_mop'(r_a_nrm[w_jj]);
            end
            cdlos_pkg::DS_MM: begin
                w_dot_a = cdlos_pkg::t_mop'(r_m[w_jj][NB-1:0]);
                w_dot_b = cdlos_pkg::t_mop'(r_m[w_jj][NB-1:0]);
            end
            cdlos_pkg::DS_VA: begin
                w_dot_a = cdlos_pkg::t_mop'(w_v[w_jj]);
                w_dot_b = cdlos_pkg::t_mop'(r_a_nrm[w_jj]);
            end
            cdlos_pkg::DS_VB: begin
                w_dot_a = cdlos_pkg::t_mop'(w_v[w_jj]);
                w_dot_b = cdlos_pkg::t_mop'(r_nrm[w_jj]);
            end
            cdlos_pkg::DS_UN: begin
                w_dot_a = cdlos_pkg::t_mop'(r_u[w_jj]);
                w_dot_b = cdlos_pkg::t_mop'(w_nbn[w_jj]);
            end
            cdlos_pkg::DS_DN: begin
                w_dot_a = cdlos_pkg::t_mop'(r_d[w_jj]);
                w_dot_b = cdlos_pkg::t_mop'(w_nbn[w_jj]);
            end
            default: begin
                w_dot_a = '0;
                w_dot_b = '0;
            end
        endcase
    end

    // Multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_AP_MUL: begin
                w_mul_a = cdlos_pkg::t_mop'(r_vol);
                w_mul_b = cdlos_pkg::t_mop'(cdlos_pkg::VOL_K);
            end
            ST_CB_SQ: begin
                w_mul_a = cdlos_pkg::t_mop'(w_tr);
                w_mul_b = cdlos_pkg::t_mop'(w_tr);
            end
            ST_CB_LO: begin
                w_mul_a = cdlos_pkg::t_mop'(w_prod[31:0]);
                w_mul_b = cdlos_pkg::t_mop'(w_tr);
            end
            ST_CB_HI: begin
                w_mul_a = cdlos_pkg::t_mop'(r_sq_hi);
                w_mul_b = cdlos_pkg::t_mop'(w_tr);
            end
            ST_RS_MUL: begin
                w_mul_a = cdlos_pkg::t_mop'(r_c);
                w_mul_b = cdlos_pkg::t_mop'(r_c);
            end
            ST_DOT: begin
                w_mul_a = w_dot_a;
                w_mul_b = w_dot_b;
            end
            ST_CS_SQ: begin
                w_mul_a = cdlos_pkg::t_mop'(r_s);
                w_mul_b = cdlos_pkg::t_mop'(r_s);
            end
            ST_AX_MUL: begin
                w_mul_a = cdlos_pkg::t_mop'(w_absd);
                w_mul_b = cdlos_pkg::t_mop'(r_lam);
            end
            ST_AX_SQ: begin
                w_mul_a = cdlos_pkg::t_mop'(r_em);
                w_mul_b = cdlos_pkg::t_mop'(r_em);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // New list entry, written in the last append cycle
    assign w_mem_we        = (r_state == ST_RS_WR);
    assign w_wdata.id      = r_id;
    assign w_wdata.pos_x   = r_pos[0];
    assign w_wdata.pos_y   = r_pos[1];
    assign w_wdata.pos_z   = r_pos[2];
    assign w_wdata.nrm_x   = r_nrm[0];
    assign w_wdata.nrm_y   = r_nrm[1];
    assign w_wdata.nrm_z   = r_nrm[2];
    assign w_wdata.broken  = r_brk;
    assign w_wdata.rsq     = w_prod[47:16];

    cdlos_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    cdlos_nb_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_nb_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_a_id    <= '0;
            r_a_brk   <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_a_pos[i] <= '0;
                r_a_nrm[i] <= '0;
            end
        end else begin
            // Drop the result once taken; the result state reloads it itself
            if (r_o_valid && i_out_ready && (r_state != ST_RESULT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_op     <= i_op;
                        r_id     <= i_particle_id;
                        r_pos[0] <= i_pos_x;
                        r_pos[1] <= i_pos_y;
                        r_pos[2] <= i_pos_z;
                        r_nrm[0] <= i_norm_x;
                        r_nrm[1] <= i_norm_y;
                        r_nrm[2] <= i_norm_z;
                        r_brk    <= i_broken;
                        r_vol    <= i_volume;
                        case (i_op)
                            cdlos_pkg::OP_CLEAR: begin
                                r_count <= '0;
                                r_ovf   <= 1'b0;
                            end
                            cdlos_pkg::OP_APPEND: begin
                                if (r_count == CW'(LIST_DEPTH)) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_state <= ST_AP_MUL;
                                end
                            end
                            cdlos_pkg::OP_SET_A: begin
                                r_a_id     <= i_particle_id;
                                r_a_pos[0] <= i_pos_x;
                                r_a_pos[1] <= i_pos_y;
                                r_a_pos[2] <= i_pos_z;
                                r_a_nrm[0] <= i_norm_x;
                                r_a_nrm[1] <= i_norm_y;
                                r_a_nrm[2] <= i_norm_z;
                                r_a_brk    <= i_broken;
                            end
                            cdlos_pkg::OP_QPOINT, cdlos_pkg::OP_QPAIR: begin
                                r_state <= ST_Q_DIFF;
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                // Radius from volume: T, then cube root bit by bit, then square
                ST_AP_MUL: r_state <= ST_AP_T;
                ST_AP_T: begin
                    r_t     <= w_prod[61:32];
                    r_c     <= '0;
                    r_bit   <= 5'(cdlos_pkg::CUBE_MSB);
                    r_state <= ST_CB_SQ;
                end
                ST_CB_SQ: r_state <= ST_CB_LO;
                ST_CB_LO: begin
                    r_sq_hi <= w_prod[43:32];
                    r_state <= ST_CB_HI;
                end
                ST_CB_HI: begin
                    r_lo    <= w_prod[53:0];
                    r_state <= ST_CB_CMP;
                end
                ST_CB_CMP: begin
                    if (w_cube <= 67'({r_t, 32'd0})) begin
                        r_c <= w_tr;
                    end
                    if (r_bit == 5'd0) begin
                        r_state <= ST_RS_MUL;
                    end else begin
                        r_bit   <= r_bit - 5'd1;
                        r_state <= ST_CB_SQ;
                    end
                end
                ST_RS_MUL: r_state <= ST_RS_WR;
                ST_RS_WR: begin
                    r_count <= r_count + CW'(1);
                    r_state <= ST_IDLE;
                end

                // Query setup
                ST_Q_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_d[i]    <= w_diff[i];
                        r_dneg[i] <= w_diff[i][32];
                        r_m[i]    <= w_diff[i][32] ? 32'(-w_diff[i]) : 32'(w_diff[i]);
                    end
                    r_vis <= 1'b1;
                    r_k   <= '0;
                    if (r_op == cdlos_pkg::OP_QPAIR) begin
                        r_state <= ST_NORM;
                    end else if (r_a_brk) begin
                        r_dsel  <= cdlos_pkg::DS_DA;
                        r_ret   <= ST_PT_CHK;
                        r_j     <= 2'd0;
                        r_state <= ST_DOT;
                    end else begin
                        r_state <= ST_WALK;
                    end
                end
                ST_PT_CHK: begin
                    if (r_acc > 52'sd0) begin
                        r_vis   <= 1'b0;
                        r_state <= ST_RESULT;
                    end else begin
                        r_state <= ST_WALK;
                    end
                end

                // Shift magnitudes together until all fit the cosine test
                ST_NORM: begin
                    if (w_norm_big) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] >> 1;
                        end
                    end else begin
                        r_dsel  <= cdlos_pkg::DS_MM;
                        r_ret   <= ST_CS_DD;
                        r_j     <= 2'd0;
                        r_state <= ST_DOT;
                    end
                end
                ST_CS_DD: begin
                    r_dd   <= r_acc[29:0];
                    r_hide <= 1'b1;
                    if (r_a_brk) begin
                        r_cos_neg <= 1'b0;
                        r_dsel    <= cdlos_pkg::DS_VA;
                        r_ret     <= ST_CS_S;
                        r_j       <= 2'd0;
                        r_state   <= ST_DOT;
                    end else if (r_brk) begin
                        r_cos_neg <= 1'b1;
                        r_dsel    <= cdlos_pkg::DS_VB;
                        r_ret     <= ST_CS_S;
                        r_j       <= 2'd0;
                        r_state   <= ST_DOT;
                    end else begin
                        r_state <= ST_WALK;
                    end
                end
                ST_CS_S: begin
                    r_s     <= r_acc[31:0];
                    r_state <= ST_CS_SQ;
                end
                ST_CS_SQ: r_state <= ST_CS_EV;
                ST_CS_EV: begin
                    if (!r_cos_neg && r_brk) begin
                        r_hide    <= w_hide_n;
                        r_cos_neg <= 1'b1;
                        r_dsel    <= cdlos_pkg::DS_VB;
                        r_ret     <= ST_CS_S;
                        r_j       <= 2'd0;
                        r_state   <= ST_DOT;
                    end else if (w_hide_n) begin
                        r_vis   <= 1'b0;
                        r_state <= ST_RESULT;
                    end else begin
                        r_state <= ST_WALK;
                    end
                end

                // Walk the neighbor list
                ST_WALK: begin
                    if (r_k >= r_count) begin
                        r_state <= ST_RESULT;
                    end else begin
                        r_state <= ST_WK_CHK;
                    end
                end
                ST_WK_CHK: begin
                    if (w_skip) begin
                        r_k     <= r_k + CW'(1);
                        r_state <= ST_WALK;
                    end else begin
                        r_nb   <= w_rdata;
                        r_u[0] <= 33'(r_a_pos[0]) - 33'(w_rdata.pos_x);
                        r_u[1] <= 33'(r_a_pos[1]) - 33'(w_rdata.pos_y);
                        r_u[2] <= 33'(r_a_pos[2]) - 33'(w_rdata.pos_z);
                        r_dsel  <= cdlos_pkg::DS_UN;
                        r_ret   <= ST_WK_AN;
                        r_j     <= 2'd0;
                        r_state <= ST_DOT;
                    end
                end
                ST_WK_AN: begin
                    r_an    <= r_acc;
                    r_dsel  <= cdlos_pkg::DS_DN;
                    r_ret   <= ST_WK_BN;
                    r_j     <= 2'd0;
                    r_state <= ST_DOT;
                end
                ST_WK_BN: begin
                    r_sum <= '0;
                    r_j   <= 2'd0;
                    r_bm  <= w_bm;
                    if (w_miss_rng) begin
                        r_k     <= r_k + CW'(1);
                        r_state <= ST_WALK;
                    end else if (w_am == w_bm) begin
                        r_lam   <= 31'd1 << cdlos_pkg::DIV_STEPS;
                        r_state <= ST_AX_MUL;
                    end else begin
                        r_rem   <= w_am;
                        r_lam   <= '0;
                        r_cnt   <= 5'(cdlos_pkg::DIV_STEPS);
                        r_state <= ST_DIV;
                    end
                end

                // Shift-subtract divide, one quotient bit per cycle
                ST_DIV: begin
                    if (w_rem2 >= 52'(r_bm)) begin
                        r_rem <= 51'(w_rem2 - 52'(r_bm));
                        r_lam <= {r_lam[29:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[50:0];
                        r_lam <= {r_lam[29:0], 1'b0};
                    end
                    if (r_cnt == 5'd1) begin
                        r_state <= ST_AX_MUL;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end

                // Crossing point offset from the neighbor, one axis per pass
                ST_AX_MUL: r_state <= ST_AX_E;
                ST_AX_E: begin
                    if (|w_em[34:30]) begin
                        r_k     <= r_k + CW'(1);
                        r_state <= ST_WALK;
                    end else begin
                        r_em    <= w_em[29:0];
                        r_state <= ST_AX_SQ;
                    end
                end
                ST_AX_SQ: r_state <= ST_AX_ACC;
                ST_AX_ACC: begin
                    r_sum <= w_sum_n;
                    if (r_j == 2'd2) begin
                        r_j <= 2'd0;
                        if (w_sum_n < {14'd0, r_nb.rsq, 16'd0}) begin
                            r_vis   <= 1'b0;
                            r_state <= ST_RESULT;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= ST_WALK;
                        end
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= ST_AX_MUL;
                    end
                end

                // Three-term dot product through the shared multiplier
                ST_DOT: begin
                    if (r_j != 2'd0) begin
                        r_acc <= w_acc_n;
                    end
                    if (r_j == 2'd3) begin
                        r_j     <= 2'd0;
                        r_state <= r_ret;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end

                // Hand the answer to the output register
                ST_RESULT: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_vis   <= r_vis;
                        r_o_ovf   <= r_ovf;
                        r_state   <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The list never grows past its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("neighbor count beyond list depth");

    // An entry is written only into free space
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_count < CW'(LIST_DEPTH)))
        else $error("neighbor write with a full list");

    // A clear empties the list and the overflow flag
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_op == cdlos_pkg::OP_CLEAR)) |=> ((r_count == '0) && !r_ovf))
        else $error("clear did not empty the list");

    // The overflow flag falls only through a clear
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ovf) |-> $past(w_in_acc && (i_op == cdlos_pkg::OP_CLEAR)))
        else $error("overflow flag dropped without a clear");

    // A finished query lands in the output register and frees the input
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RESULT) && (!r_o_valid || i_out_ready))
            |=> (r_o_valid && (r_state == ST_IDLE)))
        else $error("result not loaded");

endmodule

[rtl/core/cdlos_nb_mem.sv]
// Neighbor list storage: one write port, one registered read port.
// Depends on cdlos_pkg for the entry layout.
module cdlos_nb_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  cdlos_pkg::t_nb_entry  i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output cdlos_pkg::t_nb_entry  o_rdata
);

    cdlos_pkg::t_nb_entry r_mem [DEPTH];
    cdlos_pkg::t_nb_entry r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/cdlos_mul.sv]
// Shared signed 34x34 multiplier with a registered product.
// Depends on cdlos_pkg for operand and product types.
module cdlos_mul (
    input  logic                i_clk,
    input  cdlos_pkg::t_mop     i_a,
    input  cdlos_pkg::t_mop     i_b,
    output cdlos_pkg::t_prod    o_prod
);

    cdlos_pkg::t_prod r_prod;

    // Multiply every cycle; the sequencer picks up the registered product in the cycle after
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
